[rtl/rde_pkg.sv]
// ----------------------------------------------------------------------------
// rde_pkg
// Shared types, codes and defaults for the reversible deque engine.
// ----------------------------------------------------------------------------
package rde_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int ELEM_W_DEF = 8;
  localparam int ACTION_W   = 2;
  localparam int VALUE_W    = 8;
  localparam int KIND_W     = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD    = 2'd0,
    ACT_REVERSE = 2'd1,
    ACT_DELETE  = 2'd2,
    ACT_FINISH  = 2'd3
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ELEM  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_DRAIN
  } drain_state_t;

  // finish request from the queue state to the drain sequencer
  typedef struct packed {
    logic  start;
    kind_t kind;
  } finish_req_t;

endpackage

[rtl/rde_chan_if.sv]
// ----------------------------------------------------------------------------
// rde_chan_if
// Valid/ready channels for deque actions and for emitted results.
// ----------------------------------------------------------------------------
interface rde_in_if import rde_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [VALUE_W-1:0]  element_value;

  modport source (output valid, action, element_value, input ready);
  modport sink (input valid, action, element_value, output ready);
endinterface

interface rde_out_if import rde_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  result_kind;
  logic [VALUE_W-1:0] result_value;
  logic               last_result;

  modport source (output valid, result_kind, result_value, last_result, input ready);
  modport sink (input valid, result_kind, result_value, last_result, output ready);
endinterface

[rtl/rde_ram.sv]
// ----------------------------------------------------------------------------
// rde_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds while no read is issued
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/rde_qstate.sv]
// ----------------------------------------------------------------------------
// rde_qstate
// Ring pointers, count, reverse bit and error flag; memory write address.
// ----------------------------------------------------------------------------
module rde_qstate import rde_pkg::*; #(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int ELEM_W = ELEM_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       op_fire,
  input  action_t                    op_action,
  input  logic [VALUE_W-1:0]         op_value,
  output logic                       wr_en,
  output logic [$clog2(DEPTH)-1:0]   wr_addr,
  output logic [ELEM_W-1:0]          wr_data,
  output finish_req_t                fin_req,
  output logic [$clog2(DEPTH)-1:0]   fin_first,
  output logic [$clog2(DEPTH+1)-1:0] fin_count,
  output logic                       fin_rev
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             rev_r, rev_nxt;
  logic             err_r, err_nxt;

  logic [SUM_W-1:0] back_sum;
  logic [PTR_W-1:0] back_slot;
  logic [PTR_W-1:0] tail_slot;
  logic [PTR_W-1:0] head_inc;
  logic             full;

  // physical slot one past the last element, wrapped once
  assign back_sum  = SUM_W'(head_r) + SUM_W'(count_r);
  assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(back_sum);
  assign tail_slot = (back_slot == '0) ? PTR_LAST : back_slot - PTR_W'(1);
  assign head_inc  = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
  assign full      = (count_r == CNT_W'(DEPTH));

  assign wr_en   = op_fire && (op_action == ACT_LOAD) && !err_r && !full;
  assign wr_addr = back_slot;
  assign wr_data = ELEM_W'(op_value);

  always_comb begin
    fin_req.start = op_fire && (op_action == ACT_FINISH);
    if (err_r) begin
      fin_req.kind = KIND_ERROR;
    end else if (count_r == '0) begin
      fin_req.kind = KIND_EMPTY;
    end else begin
      fin_req.kind = KIND_ELEM;
    end
  end

  assign fin_first = rev_r ? tail_slot : head_r;
  assign fin_count = count_r;
  assign fin_rev   = rev_r;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    rev_nxt   = rev_r;
    err_nxt   = err_r;
    if (op_fire) begin
      case (op_action)
        ACT_LOAD: begin
          if (!err_r && !full) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        ACT_REVERSE: begin
          if (!err_r) begin
            rev_nxt = !rev_r;
          end
        end
        ACT_DELETE: begin
          if (!err_r) begin
            if (count_r == '0) begin
              err_nxt = 1'b1;
            end else begin
              if (!rev_r) begin
                head_nxt = head_inc;
              end
              count_nxt = count_r - CNT_W'(1);
            end
          end
        end
        ACT_FINISH: begin
          head_nxt  = '0;
          count_nxt = '0;
          rev_nxt   = 1'b0;
          err_nxt   = 1'b0;
        end
        default: begin
          head_nxt = head_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

[rtl/rde_drain.sv]
// ----------------------------------------------------------------------------
// rde_drain
// Finish sequencer: walks the ring through the RAM read port into the output
// register, or emits a single error or empty-list result.
// ----------------------------------------------------------------------------
module rde_drain import rde_pkg::*; #(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int ELEM_W = ELEM_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  finish_req_t                fin_req,
  input  logic [$clog2(DEPTH)-1:0]   fin_first,
  input  logic [$clog2(DEPTH+1)-1:0] fin_count,
  input  logic                       fin_rev,
  output logic                       rd_en,
  output logic [$clog2(DEPTH)-1:0]   rd_addr,
  input  logic [ELEM_W-1:0]          rd_data,
  output logic                       busy,
  output logic                       out_valid,
  output logic [KIND_W-1:0]          out_kind,
  output logic [VALUE_W-1:0]         out_value,
  output logic                       out_last,
  input  logic                       out_ready
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WIDE_W = (ELEM_W > VALUE_W) ? ELEM_W : VALUE_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  drain_state_t       state_r, state_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   left_r, left_nxt;
  logic               dir_r, dir_nxt;
  kind_t              pend_r, pend_nxt;
  logic               ov_r, ov_nxt;
  logic [KIND_W-1:0]  okind_r, okind_nxt;
  logic [VALUE_W-1:0] oval_r, oval_nxt;
  logic               olast_r, olast_nxt;

  logic               out_free;
  logic               load_out;
  logic [PTR_W-1:0]   step_src;
  logic               step_dir;
  logic [PTR_W-1:0]   step_ptr;
  logic [WIDE_W-1:0]  rd_wide;

  assign out_free = !ov_r || out_ready;
  assign rd_wide  = WIDE_W'(rd_data);

  // next ring slot in walk direction
  always_comb begin
    if (state_r == ST_IDLE) begin
      step_src = fin_first;
      step_dir = fin_rev;
    end else begin
      step_src = ptr_r;
      step_dir = dir_r;
    end
    if (step_dir) begin
      step_ptr = (step_src == '0) ? PTR_LAST : step_src - PTR_W'(1);
    end else begin
      step_ptr = (step_src == PTR_LAST) ? '0 : step_src + PTR_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    left_nxt  = left_r;
    dir_nxt   = dir_r;
    pend_nxt  = pend_r;
    rd_en     = 1'b0;
    rd_addr   = step_src;
    load_out  = 1'b0;
    okind_nxt = okind_r;
    oval_nxt  = oval_r;
    olast_nxt = olast_r;
    case (state_r)
      ST_IDLE: begin
        if (fin_req.start) begin
          if (fin_req.kind == KIND_ELEM) begin
            rd_en     = 1'b1;
            ptr_nxt   = step_ptr;
            left_nxt  = fin_count;
            dir_nxt   = fin_rev;
            state_nxt = ST_DRAIN;
          end else begin
            pend_nxt  = fin_req.kind;
            state_nxt = ST_SINGLE;
          end
        end
      end
      ST_SINGLE: begin
        if (out_free) begin
          load_out  = 1'b1;
          okind_nxt = pend_r;
          oval_nxt  = '0;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          load_out  = 1'b1;
          okind_nxt = KIND_ELEM;
          oval_nxt  = rd_wide[VALUE_W-1:0];
          olast_nxt = (left_r == CNT_W'(1));
          left_nxt  = left_r - CNT_W'(1);
          if (left_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            ptr_nxt = step_ptr;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (load_out) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    left_r  <= left_nxt;
    dir_r   <= dir_nxt;
    pend_r  <= pend_nxt;
    okind_r <= okind_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_kind  = okind_r;
  assign out_value = oval_r;
  assign out_last  = olast_r;

endmodule

[rtl/reversible_deque_engine.sv]
// load, reverse and delete: one transaction per cycle while no finish is being emitted,
//   state updated at the accepting edge; finish with error or empty list: one result in
//   the output register; finish with n elements: each through the RAM read register into
//   the output register, one per cycle while the sink takes them; input is held off until
//   the last is loaded; the rate is set by the single registered read port of the memory
// synchronous reset (rst_n low) clears head, count, flags, output valid; memory is kept
// ----------------------------------------------------------------------------
// reversible_deque_engine
// Ring-buffer deque with a reverse flag, emitting its contents on finish.
// ----------------------------------------------------------------------------
module reversible_deque_engine import rde_pkg::*; #(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int ELEM_W = ELEM_W_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rde_in_if.sink    in_chan,
  rde_out_if.source out_chan
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // handshake on the action channel
  logic in_fire;
  logic busy;

  // memory write side, driven by the queue state
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic [ELEM_W-1:0] wr_data;

  // memory read side, driven by the drain sequencer
  logic              rd_en;
  logic [PTR_W-1:0]  rd_addr;
  logic [ELEM_W-1:0] rd_data;

  // finish hand-off
  finish_req_t       fin_req;
  logic [PTR_W-1:0]  fin_first;
  logic [CNT_W-1:0]  fin_count;
  logic              fin_rev;

  // no new action while a finish is being emitted; a waiting last result
  // does not block loads that follow it
  assign in_chan.ready = !busy;
  assign in_fire       = in_chan.valid && !busy;

  // pointers, count, reverse bit and error flag
  rde_qstate #(
    .DEPTH  (DEPTH),
    .ELEM_W (ELEM_W)
  ) u_qstate (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_fire   (in_fire),
    .op_action (action_t'(in_chan.action)),
    .op_value  (in_chan.element_value),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .fin_req   (fin_req),
    .fin_first (fin_first),
    .fin_count (fin_count),
    .fin_rev   (fin_rev)
  );

  // element storage; a load writes at the edge before any finish can read,
  // and loads never overlap a drain, so no forwarding is needed
  rde_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // finish sequencer and output register
  rde_drain #(
    .DEPTH  (DEPTH),
    .ELEM_W (ELEM_W)
  ) u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_req   (fin_req),
    .fin_first (fin_first),
    .fin_count (fin_count),
    .fin_rev   (fin_rev),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .busy      (busy),
    .out_valid (out_chan.valid),
    .out_kind  (out_chan.result_kind),
    .out_value (out_chan.result_value),
    .out_last  (out_chan.last_result),
    .out_ready (out_chan.ready)
  );

endmodule

[rtl/rde_checker.sv]
// ----------------------------------------------------------------------------
// rde_checker
// Port-level checks on the deque engine, bound to the top level.
// ----------------------------------------------------------------------------
module rde_checker import rde_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [ACTION_W-1:0] in_action,
  input logic                out_valid,
  input logic                out_ready,
  input logic [KIND_W-1:0]   out_kind,
  input logic [VALUE_W-1:0]  out_value,
  input logic                out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_kind) && $stable(out_value) && $stable(out_last))
    else $error("result changed while stalled");

  // error and empty-list results are single, zero-valued and last
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_ELEM) |-> (out_value == '0) && out_last)
    else $error("non-element result malformed");

  // a finish holds off the action channel in the next cycle
  a_finish_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_FINISH) |=> !in_ready)
    else $error("action accepted right after finish");

  // a new result only appears while a finish is being emitted
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result produced outside a finish");

endmodule

bind reversible_deque_engine rde_checker u_rde_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_action (in_chan.action),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.result_kind),
  .out_value (out_chan.result_value),
  .out_last  (out_chan.last_result)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the reversible deque engine. A short table of
// actions covers the corner cases. Random cases of loads, reverses and
// deletes follow, all but noise cases closed by a finish. A shadow deque
// predicts every result not typed in the table. Both channels idle in
// random bursts; one long output hold backs the block up with a full store.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rde_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 4;
  localparam int RAND_ITEMS   = 200;  // size of the random part
  localparam int TAIL_ITEMS   = 30;   // last items run with no idling
  localparam int LONG_HOLD    = 300;  // receiver hold-off, in cycles
  localparam int DRAIN_TAIL   = 16;   // settle time after the last result
  localparam int MAX_PRINTS   = 50;
  // far beyond the slowest correct run
  localparam int WATCHDOG_NS  = 2_000_000;

  typedef enum int {
    CASE_CLEAN,
    CASE_BROKEN,
    CASE_NOISE,
    CASE_FILL
  } case_style_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } deque_result_t;

  typedef struct packed {
    action_t    act;
    logic [7:0] val;
  } deque_op_t;

  // one directed row: an action and, where obvious, its single result
  typedef struct packed {
    action_t    act;
    logic [7:0] val;
    logic       typed;
    kind_t      kind;
  } step_row_t;

  localparam int DIR_ROWS = 23;
  localparam step_row_t DIR_TAB [DIR_ROWS] = '{
    '{ACT_FINISH,  8'h00, 1'b1, KIND_EMPTY},  // fresh after reset: empty list
    '{ACT_DELETE,  8'h00, 1'b0, KIND_ELEM},   // delete from empty latches error
    '{ACT_LOAD,    8'hAA, 1'b0, KIND_ELEM},   // ignored while error is latched
    '{ACT_REVERSE, 8'h00, 1'b0, KIND_ELEM},   // ignored too
    '{ACT_DELETE,  8'h00, 1'b0, KIND_ELEM},   // ignored too
    '{ACT_FINISH,  8'h00, 1'b1, KIND_ERROR},
    '{ACT_LOAD,    8'h00, 1'b0, KIND_ELEM},   // value extremes
    '{ACT_LOAD,    8'hFF, 1'b0, KIND_ELEM},
    '{ACT_LOAD,    8'h55, 1'b0, KIND_ELEM},
    '{ACT_REVERSE, 8'hFF, 1'b0, KIND_ELEM},
    '{ACT_DELETE,  8'hFF, 1'b0, KIND_ELEM},   // pops the physical back
    '{ACT_LOAD,    8'hA5, 1'b0, KIND_ELEM},
    '{ACT_FINISH,  8'hFF, 1'b0, KIND_ELEM},   // drain in reversed order
    '{ACT_REVERSE, 8'h00, 1'b0, KIND_ELEM},
    '{ACT_DELETE,  8'h00, 1'b0, KIND_ELEM},   // error while reversed
    '{ACT_FINISH,  8'h00, 1'b1, KIND_ERROR},
    '{ACT_LOAD,    8'h01, 1'b0, KIND_ELEM},
    '{ACT_DELETE,  8'h00, 1'b0, KIND_ELEM},   // back to empty, no error
    '{ACT_FINISH,  8'h00, 1'b1, KIND_EMPTY},
    '{ACT_LOAD,    8'h80, 1'b0, KIND_ELEM},
    '{ACT_DELETE,  8'h00, 1'b0, KIND_ELEM},   // head moves forward
    '{ACT_LOAD,    8'h7F, 1'b0, KIND_ELEM},
    '{ACT_FINISH,  8'h00, 1'b0, KIND_ELEM}
  };

  logic clk = 1'b0;
  logic rst_n;

  rde_in_if  in_if ();
  rde_out_if out_if ();

  reversible_deque_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #(CLK_HALF) clk = ~clk;

  // shadow deque, updated at every accepted input transaction
  logic [7:0] shadow_mem [DEPTH_DEF];
  logic [5:0] shadow_head;
  logic [6:0] shadow_count;
  logic       shadow_rev;
  logic       shadow_err;

  deque_result_t pending_results [$];
  deque_op_t     op_q [$];

  // pacing controls shared between the sender, the receiver and the sequence
  bit src_quiet;
  bit quiet_tail;
  bit hold_req;

  int mismatch_count;
  int n_items;
  int n_results;
  int n_dropped;
  int n_error_cases;
  int n_full_drains;
  int n_long_holds;

  task automatic report_mismatch(input string msg);
    // keep the log short once a broken block floods it
    if (mismatch_count < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // append an expected result at the tail of the scoreboard
  function automatic void add_result(input deque_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // append one action at the tail of the random sequence
  function automatic void add_op(input deque_op_t op);
    op_q.insert(op_q.size(), op);
  endfunction

  function automatic void deque_clear();
    shadow_head  = '0;
    shadow_count = '0;
    shadow_rev   = 1'b0;
    shadow_err   = 1'b0;
  endfunction

  // applies one action to the shadow deque; a finish queues what it emits
  function automatic void deque_apply(input action_t act, input logic [7:0] val,
                                      input bit emit);
    logic [5:0]    slot;
    logic [6:0]    off;
    deque_result_t res;
    case (act)
      ACT_LOAD: begin
        if (!shadow_err) begin
          if (shadow_count < 7'(DEPTH_DEF)) begin
            slot = shadow_head + shadow_count[5:0];
            shadow_mem[slot] = val;
            shadow_count++;
          end else begin
            n_dropped++;
          end
        end
      end
      ACT_REVERSE: begin
        if (!shadow_err) shadow_rev = !shadow_rev;
      end
      ACT_DELETE: begin
        if (!shadow_err) begin
          if (shadow_count == 0) begin
            shadow_err = 1'b1;
          end else begin
            // reversed: the logical front is the physical back
            if (!shadow_rev) shadow_head++;
            shadow_count--;
          end
        end
      end
      default: begin
        if (shadow_err) begin
          n_error_cases++;
          if (emit) add_result('{KIND_ERROR, 8'h00, 1'b1});
        end else if (shadow_count == 0) begin
          if (emit) add_result('{KIND_EMPTY, 8'h00, 1'b1});
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            off = shadow_rev ? (shadow_count - 7'(i) - 7'd1) : 7'(i);
            slot = shadow_head + off[5:0];
            res.kind  = KIND_ELEM;
            res.value = shadow_mem[slot];
            res.last  = (i == shadow_count - 1);
            if (emit) add_result(res);
          end
          if (shadow_count == 7'(DEPTH_DEF)) n_full_drains++;
        end
        deque_clear();
      end
    endcase
  endfunction

  // one random case of actions; all but noise end with a finish
  task automatic queue_case(input case_style_t style);
    int        held;
    int        steps;
    int        pick;
    deque_op_t op;
    held  = 0;
    steps = (style == CASE_FILL) ? DEPTH_DEF + 6 : $urandom_range(1, 24);
    for (int i = 0; i < steps; i++) begin
      op.val = 8'($urandom_range(0, 255));
      if (style == CASE_NOISE) begin
        op.act = action_t'($urandom_range(0, 3));
      end else if (style == CASE_FILL) begin
        op.act = (i % 24 == 7) ? ACT_REVERSE : ACT_LOAD;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 5 || (pick >= 7 && held == 0)) begin
          op.act = ACT_LOAD;
          held++;
        end else if (pick < 7) begin
          op.act = ACT_REVERSE;
        end else begin
          op.act = ACT_DELETE;
          held--;
        end
      end
      add_op(op);
    end
    if (style == CASE_BROKEN) begin
      // one delete too many, then a few actions that must be ignored
      for (int i = 0; i <= held; i++) add_op('{ACT_DELETE, 8'h00});
      for (int i = 0; i < $urandom_range(1, 3); i++)
        add_op('{action_t'($urandom_range(0, 2)), 8'($urandom_range(0, 255))});
    end
    if (style == CASE_FILL) begin
      // free one slot, refill it, then one more load that gets dropped
      add_op('{ACT_DELETE, 8'h00});
      add_op('{ACT_LOAD, 8'($urandom_range(0, 255))});
      add_op('{ACT_LOAD, 8'($urandom_range(0, 255))});
    end
    if (style != CASE_NOISE) add_op('{ACT_FINISH, 8'($urandom_range(0, 255))});
  endtask

  // offers one transaction and returns at the edge that accepts it
  task automatic send_item(input action_t act, input logic [7:0] val);
    int gap;
    @(negedge clk);
    if (!src_quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.action        <= act;
    in_if.element_value <= val;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    n_items++;
  endtask

  // result receiver: random stall bursts, ready stretches, one long hold
  initial begin : result_sink
    int burst;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
        n_long_holds++;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        burst = $urandom_range(1, 14);
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_if.ready <= 1'b1;
        burst = $urandom_range(0, 20);
        repeat (burst) @(negedge clk);
      end
    end
  end

  // every accepted result is checked against the oldest expectation
  always @(posedge clk) begin : result_check
    deque_result_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d value %02h last %0d",
                                  out_if.result_kind, out_if.result_value,
                                  out_if.last_result));
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_if.result_kind !== want.kind)
          report_mismatch($sformatf("result_kind got %0d want %0d",
                                    out_if.result_kind, want.kind));
        if (out_if.result_value !== want.value)
          report_mismatch($sformatf("result_value got %02h want %02h",
                                    out_if.result_value, want.value));
        if (out_if.last_result !== want.last)
          report_mismatch($sformatf("last_result got %0d want %0d",
                                    out_if.last_result, want.last));
      end
    end
  end

  initial begin : stimulus
    int press_lo;
    int press_hi;
    bit fill_done;
    int pick;
    in_if.valid         <= 1'b0;
    in_if.action        <= ACT_LOAD;
    in_if.element_value <= '0;
    rst_n               <= 1'b0;
    deque_clear();
    press_lo  = -1;
    press_hi  = -1;
    fill_done = 1'b0;

    // random cases, with one full-store case a third of the way in
    while (op_q.size() < RAND_ITEMS) begin
      if (!fill_done && op_q.size() >= RAND_ITEMS / 3) begin
        press_lo = op_q.size();
        queue_case(CASE_FILL);
        press_hi  = op_q.size();
        fill_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) queue_case(CASE_CLEAN);
        else if (pick < 8) queue_case(CASE_BROKEN);
        else queue_case(CASE_NOISE);
      end
    end
    // close any case left open by noise
    add_op('{ACT_FINISH, 8'h00});

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed table: typed expectations where the answer is obvious
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_item(DIR_TAB[r].act, DIR_TAB[r].val);
      if (DIR_TAB[r].typed) begin
        add_result('{DIR_TAB[r].kind, 8'h00, 1'b1});
        deque_apply(DIR_TAB[r].act, DIR_TAB[r].val, 1'b0);
      end else begin
        deque_apply(DIR_TAB[r].act, DIR_TAB[r].val, 1'b1);
      end
    end

    // random part; the sender keeps going through the long output hold
    for (int k = 0; k < op_q.size(); k++) begin
      quiet_tail = (k >= op_q.size() - TAIL_ITEMS);
      src_quiet  = quiet_tail || (k >= press_lo && k < press_hi);
      if (k == press_lo) hold_req = 1'b1;
      send_item(op_q[k].act, op_q[k].val);
      deque_apply(op_q[k].act, op_q[k].val, 1'b1);
    end
    @(negedge clk);
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("summary: %0d input transactions, %0d results, %0d full-store drains",
             n_items, n_results, n_full_drains);
    $display("summary: %0d loads dropped when full, %0d error cases, %0d long holds",
             n_dropped, n_error_cases, n_long_holds);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("status: fail");
    $finish;
  end

endmodule

[files.f]
rtl/rde_pkg.sv
rtl/rde_chan_if.sv
rtl/rde_ram.sv
rtl/rde_qstate.sv
rtl/rde_drain.sv
rtl/reversible_deque_engine.sv
rtl/rde_checker.sv
tb/tb_top.sv
